/* rtl/core/voew_pkg.sv */
`timescale 1ns / 1ps
package voew_pkg;

  localparam int unsigned MaxOrder   = 5;
  localparam int unsigned NumWeights = 6;
  localparam int unsigned NumTimes   = 7;
  localparam int unsigned WeightFrac = 40;

  typedef logic [63:0]  word_t;
  typedef logic [127:0] dword_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ORD_ZERO = 2'd1,
    ST_ORD_HIGH = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SLDA,
    S_SDIFF,
    S_NLDA,
    S_NDIFF,
    S_DLDA,
    S_DDIFF,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_FIN,
    S_ACC,
    S_OUT
  } state_e;

  // commands to the shared multiply / divide unit
  typedef struct packed {
    logic start_mul;
    logic start_div;
  } md_ctrl_t;

endpackage

/* rtl/core/voew_muldiv.sv */
`timescale 1ns / 1ps
// shared shift-add multiplier and restoring divider over one 128-bit register
module voew_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  voew_pkg::md_ctrl_t ctrl_i,
  input  voew_pkg::word_t   mul_a_i,
  input  voew_pkg::word_t   mul_b_i,
  input  voew_pkg::word_t   div_d_i,
  output logic              busy_o,
  output voew_pkg::dword_t  result_o
);
  import voew_pkg::*;

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  dword_t      acc_q, acc_d;
  word_t       ma_q, ma_d;
  word_t       mb_q, mb_d;
  word_t       dv_q, dv_d;
  word_t       rem_q, rem_d;
  logic [64:0] sh;
  logic [64:0] diff;

  assign sh   = {rem_q, acc_q[127]};
  assign diff = sh - {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    if (ctrl_i.start_mul) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = 7'd63;
      acc_d  = '0;
      ma_d   = mul_a_i;
      mb_d   = mul_b_i;
    end else if (ctrl_i.start_div) begin
      busy_d = 1'b1;
      div_d  = 1'b1;
      cnt_d  = 7'd127;
      rem_d  = '0;
      dv_d   = div_d_i;
    end else if (busy_q) begin
      if (!div_q) begin
        // one multiplier bit per cycle, msb first
        acc_d = {acc_q[126:0], 1'b0} + (mb_q[63] ? {64'd0, ma_q} : 128'd0);
        mb_d  = {mb_q[62:0], 1'b0};
      end else begin
        // one quotient bit per cycle
        if (!diff[64]) begin
          rem_d = diff[63:0];
          acc_d = {acc_q[126:0], 1'b1};
        end else begin
          rem_d = sh[63:0];
          acc_d = {acc_q[126:0], 1'b0};
        end
      end
      if (cnt_q == 7'd0) busy_d = 1'b0;
      else               cnt_d  = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
  end

  assign busy_o   = busy_q;
  assign result_o = acc_q;

endmodule

/* rtl/core/variable_order_extrapolation_weights_top.sv */
`timescale 1ns / 1ps
// Polynomial extrapolation weights for a variable-order predictor. One request carries the
// current time, six past times (signed Q32.32), the step number and the stepper order; one
// result carries six Q24.40 weights, an apply flag and a status code. The order is the
// fixed_order register when nonzero, else the stepper order. Requests inside the set-up steps
// or with a bad order skip the computation. Otherwise every term of the Newton form goes
// through a sign pass and then one multiply-divide step per numerator factor on a single
// shared serial unit, which first multiplies and then divides. The block takes one request
// at a time; tready is high only when it is idle.
module variable_order_extrapolation_weights_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  // apb configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // time_now, time_back1..time_back6 (64 each), step_number (32), stepper_order (3), pad
  input  logic [487:0]  s_axis_tdata,
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // weight0..weight5 (64 each), apply_predictor (1), status (2), pad
  output logic [391:0]  m_axis_tdata
);
  import voew_pkg::*;

  localparam word_t One   = word_t'(1) << WeightFrac;
  localparam word_t CapP  = {1'b0, {63{1'b1}}};
  localparam word_t CapN  = {1'b1, 63'd0};

  // configuration register
  logic [2:0] fixed_order_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_order_q <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      fixed_order_q <= pwdata[2:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, fixed_order_q};

  // sequencer state
  state_e      state_q, state_d;
  word_t       t_q [NumTimes];
  logic [2:0]  order_q, order_d;
  logic [2:0]  i_q, i_d;
  logic [2:0]  j_q, j_d;
  logic [3:0]  c_q, c_d;
  logic [2:0]  m_q, m_d;
  logic        s_q, s_d;
  logic        sat_q, sat_d;
  word_t       r_q, r_d;
  word_t       opa_q, opa_d;
  word_t       nm_q, nm_d;
  word_t       dm_q, dm_d;
  word_t       term_q, term_d;
  word_t       w_q [NumWeights];
  logic        w_clr;
  logic        w_we;
  word_t       w_wdata;
  status_e     stat_q, stat_d;
  logic        out_valid_q;
  logic        out_load;
  word_t       ow_q [NumWeights];
  logic        o_apply_q;
  status_e     o_stat_q;
  logic        computed_q;

  // unit interface
  md_ctrl_t    md_ctrl;
  logic        md_busy;
  dword_t      md_res;

  voew_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (md_ctrl),
    .mul_a_i  (r_q),
    .mul_b_i  (nm_q),
    .div_d_i  (dm_q),
    .busy_o   (md_busy),
    .result_o (md_res)
  );

  // request decode
  logic [2:0]  in_ord;
  logic [2:0]  in_setup;
  logic [31:0] in_step;
  logic        accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_ord   = (fixed_order_q != 3'd0) ? fixed_order_q : s_axis_tdata[482:480];
  assign in_setup = (fixed_order_q != 3'd0) ? fixed_order_q : 3'd1;
  assign in_step  = s_axis_tdata[479:448];
  assign accept   = s_axis_tvalid && s_axis_tready;

  // time read port and difference unit
  logic [2:0]  rd_idx;
  word_t       rd_val;
  logic        df_neg;
  word_t       df_mag;
  logic [2:0]  sk;   // k of the sign pass
  logic [2:0]  dk;   // k of the current denominator
  assign rd_val = t_q[rd_idx];
  assign df_neg = $signed(opa_q) < $signed(rd_val);
  assign df_mag = df_neg ? (rd_val - opa_q) : (opa_q - rd_val);
  assign sk     = 3'(c_q - {1'b0, i_q});
  assign dk     = (m_q < j_q) ? m_q : (m_q + 3'd1);

  // saturating accumulate
  logic [64:0] acc_sum;
  word_t       w_cur;
  assign w_cur   = w_q[j_q];
  assign acc_sum = {w_cur[63], w_cur} + {term_q[63], term_q};

  logic        q_ovf;
  word_t       cap;
  assign cap   = s_q ? CapN : CapP;
  assign q_ovf = (md_res[127:64] != 64'd0) || (md_res[63:0] > cap);

  always_comb begin
    state_d  = state_q;
    order_d  = order_q;
    i_d      = i_q;
    j_d      = j_q;
    c_d      = c_q;
    m_d      = m_q;
    s_d      = s_q;
    sat_d    = sat_q;
    r_d      = r_q;
    opa_d    = opa_q;
    nm_d     = nm_q;
    dm_d     = dm_q;
    term_d   = term_q;
    stat_d   = stat_q;
    w_clr    = 1'b0;
    w_we     = 1'b0;
    w_wdata  = acc_sum[63:0];
    md_ctrl  = '0;
    rd_idx   = 3'd0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          w_clr   = 1'b1;
          order_d = in_ord;
          sat_d   = 1'b0;
          i_d     = 3'd0;
          j_d     = 3'd0;
          c_d     = 4'd0;
          s_d     = 1'b0;
          r_d     = One;
          if (in_step <= {29'd0, in_setup}) begin
            stat_d  = ST_OK;
            state_d = S_OUT;
          end else if (in_ord == 3'd0) begin
            stat_d  = ST_ORD_ZERO;
            state_d = S_OUT;
          end else if (in_ord > 3'(MaxOrder)) begin
            stat_d  = ST_ORD_HIGH;
            state_d = S_OUT;
          end else begin
            stat_d  = ST_OK;
            state_d = S_SLDA;
          end
        end
      end
      // sign pass over numerator and denominator factors
      S_SLDA: begin
        if (c_q > {i_q, 1'b0}) begin
          if (i_q == 3'd0) begin
            state_d = S_FIN;
          end else begin
            m_d     = 3'd0;
            state_d = S_NLDA;
          end
        end else if (c_q < {1'b0, i_q}) begin
          rd_idx  = 3'd0;
          opa_d   = rd_val;
          state_d = S_SDIFF;
        end else if (sk == j_q) begin
          c_d = c_q + 4'd1;
        end else begin
          rd_idx  = j_q + 3'd1;
          opa_d   = rd_val;
          state_d = S_SDIFF;
        end
      end
      S_SDIFF: begin
        rd_idx  = (c_q < {1'b0, i_q}) ? (c_q[2:0] + 3'd1) : (sk + 3'd1);
        s_d     = s_q ^ df_neg;
        c_d     = c_q + 4'd1;
        state_d = S_SLDA;
      end
      // one multiply-divide step
      S_NLDA: begin
        rd_idx  = 3'd0;
        opa_d   = rd_val;
        state_d = S_NDIFF;
      end
      S_NDIFF: begin
        rd_idx  = m_q + 3'd1;
        nm_d    = df_mag;
        state_d = S_DLDA;
      end
      S_DLDA: begin
        rd_idx  = j_q + 3'd1;
        opa_d   = rd_val;
        state_d = S_DDIFF;
      end
      S_DDIFF: begin
        rd_idx = dk + 3'd1;
        dm_d   = df_mag;
        if (df_mag == 64'd0) begin
          r_d     = cap;
          sat_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          md_ctrl.start_mul = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (!md_busy) begin
          md_ctrl.start_div = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!md_busy) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (q_ovf) begin
          r_d     = cap;
          sat_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          r_d = md_res[63:0];
          if (m_q == i_q - 3'd1) begin
            state_d = S_FIN;
          end else begin
            m_d     = m_q + 3'd1;
            state_d = S_NLDA;
          end
        end
      end
      S_FIN: begin
        term_d  = s_q ? (~r_q + 64'd1) : r_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        w_we = 1'b1;
        if (acc_sum[64] != acc_sum[63]) begin
          sat_d   = 1'b1;
          w_wdata = acc_sum[64] ? CapN : CapP;
        end
        c_d = 4'd0;
        s_d = 1'b0;
        r_d = One;
        if (j_q < i_q) begin
          j_d     = j_q + 3'd1;
          state_d = S_SLDA;
        end else if (i_q < order_q) begin
          i_d     = i_q + 3'd1;
          j_d     = 3'd0;
          state_d = S_SLDA;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sat_q) stat_d = ST_SAT;
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      stat_q      <= ST_OK;
      sat_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
      sat_q   <= sat_d;
      if (out_load)                          out_valid_q <= 1'b1;
      else if (m_axis_tready)                out_valid_q <= 1'b0;
    end
  end

  // apply only for a request that ran the computation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) computed_q <= 1'b0;
    else if (accept) computed_q <= 1'b0;
    else if (state_q == S_ACC) computed_q <= 1'b1;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    order_q <= order_d;
    i_q     <= i_d;
    j_q     <= j_d;
    c_q     <= c_d;
    m_q     <= m_d;
    s_q     <= s_d;
    r_q     <= r_d;
    opa_q   <= opa_d;
    nm_q    <= nm_d;
    dm_q    <= dm_d;
    term_q  <= term_d;
    if (accept) begin
      for (int n = 0; n < NumTimes; n++) t_q[n] <= s_axis_tdata[64*n +: 64];
    end
    if (w_clr) begin
      for (int n = 0; n < NumWeights; n++) w_q[n] <= '0;
    end else if (w_we) begin
      w_q[j_q] <= w_wdata;
    end
    if (out_load) begin
      for (int n = 0; n < NumWeights; n++) ow_q[n] <= w_q[n];
      o_apply_q <= (stat_d == ST_OK) && computed_q;
      o_stat_q  <= stat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  always_comb begin
    m_axis_tdata = '0;
    for (int n = 0; n < NumWeights; n++) m_axis_tdata[64*n +: 64] = ow_q[n];
    m_axis_tdata[384]     = o_apply_q;
    m_axis_tdata[386:385] = o_stat_q;
  end

  // checks
  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !md_busy) else $error("request taken while unit busy");
  a_apply_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[384]) |-> (m_axis_tdata[386:385] == ST_OK))
    else $error("apply with bad status");
  a_check_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> !md_busy) else $error("quotient read while unit busy");
  a_bad_order_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[386:385] == ST_ORD_ZERO ||
                       m_axis_tdata[386:385] == ST_ORD_HIGH))
    |-> (m_axis_tdata[383:0] == 384'd0)) else $error("weights set for bad order");

endmodule
